// File: design/encoder_pid_motor_speed_loop_top_macros.svh
// assertion macros used by the speed loop sequencer
// depends on the clk_i and rst_ni names of the module that uses them
`ifndef ENCODER_PID_MOTOR_SPEED_LOOP_TOP_MACROS_SVH
`define ENCODER_PID_MOTOR_SPEED_LOOP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define EPSL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define EPSL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define EPSL_ASSERT_IMP(lbl, pre, post, msg)
`define EPSL_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: design/epsl_pkg.sv
// shared constants, lookup tables and controller/datapath types of the speed loop
// no dependencies
package epsl_pkg;

  localparam int COUNTER_BITS   = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int START_DELAY    = 5;
  localparam int PWM_PERIOD     = 1000;

  localparam int MAX_RPM       = 155;
  localparam int TICKS_X10     = 1986;
  localparam int RPM_SCALE_X10 = 6000;

  // field and state widths
  localparam int GAIN_W    = 16;
  localparam int RPM_W     = 8;
  localparam int DIR_W     = 2;
  localparam int MEAS_W    = 16;
  localparam int DUTY_W    = 10;
  localparam int DUTY_MAX  = 1023;
  localparam int ERR_W     = 18;
  localparam int INTEG_W   = 32;
  localparam int CS_W      = 40;
  localparam int MULB_W    = 33;
  localparam int SUM_W     = GAIN_W + 1 + MULB_W;
  localparam int WIDE_W    = 33;
  localparam int DELAY_W   = $clog2(START_DELAY + 1);
  localparam int DESIRED_W = $clog2(MAX_RPM * TICKS_X10 / RPM_SCALE_X10 + 1);

  // stream and config port widths
  localparam int IN_DATA_W   = ((COUNTER_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = MEAS_W + DUTY_W + 4;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RPM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1536;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd512;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd256;
  localparam logic [RPM_W-1:0]  TARGET_RST = 8'd1;
  localparam logic [DIR_W-1:0]  DIR_STOP   = 2'd0;
  localparam logic [DIR_W-1:0]  DIR_CW     = 2'd1;
  localparam logic [DIR_W-1:0]  DIR_CCW    = 2'd2;

  // request kind on the input tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // speed to rpm conversion: rpm = cs * 6000 / (1986 << frac), by reciprocal
  localparam longint RPM_DIV    = longint'(TICKS_X10) * (longint'(1) << GAIN_FRAC_BITS);
  localparam longint RPM_CS_MIN = (longint'(MAX_RPM) * RPM_DIV + RPM_SCALE_X10 - 1)
                                  / RPM_SCALE_X10;
  localparam int     CS_SMALL_W = $clog2(RPM_CS_MIN);
  localparam int     DIV_W      = $clog2(RPM_DIV + 1);
  localparam int     RPM_SHIFT  = CS_SMALL_W + DIV_W;
  localparam longint RPM_K      = ((longint'(RPM_SCALE_X10) << RPM_SHIFT) + RPM_DIV - 1)
                                  / RPM_DIV;
  localparam int     RPM_PW     = RPM_SHIFT + RPM_W;

  typedef logic [DESIRED_W-1:0] ticks_tab_t [MAX_RPM+1];
  typedef logic [DUTY_W-1:0]    duty_tab_t  [MAX_RPM+1];

  function automatic ticks_tab_t build_ticks_tab();
    ticks_tab_t t;
    for (int r = 0; r <= MAX_RPM; r++) begin
      t[r] = DESIRED_W'((r * TICKS_X10) / RPM_SCALE_X10);
    end
    return t;
  endfunction

  function automatic duty_tab_t build_duty_tab();
    duty_tab_t t;
    int        d;
    for (int r = 0; r <= MAX_RPM; r++) begin
      d = (r * PWM_PERIOD) / MAX_RPM;
      if (d > DUTY_MAX) d = DUTY_MAX;
      t[r] = DUTY_W'(d);
    end
    return t;
  endfunction

  localparam ticks_tab_t TICKS_TAB = build_ticks_tab();
  localparam duty_tab_t  DUTY_TAB  = build_duty_tab();

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef struct packed {
    logic     tick_load;
    logic     start_load;
    logic     err_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_first;
    logic     acc_add;
    logic     cs_step;
    logic     rpm_step;
    logic     out_load;
  } epsl_cmd_t;

  typedef struct packed {
    logic pid_go;
    logic delay_zero;
    logic sum_nz;
  } epsl_sts_t;

endpackage

// File: design/encoder_pid_motor_speed_loop_top.sv
// encoder fed pid speed loop, top level; depends on epsl_pkg, epsl_ctrl and epsl_dp
// one request at a time: a start request or a tick before pid runs goes from accept to
// the result register; a tick with pid first computes the error, the three gain products
// sharing one multiplier, the sum, the commanded speed and, on a drive update, the rpm
// reciprocal multiply; a new request is taken the cycle after the result is registered
// reset (rst_ni low, asynchronous) restores register defaults and clears the loop state
module encoder_pid_motor_speed_loop_top import epsl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  // config write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,

  // request stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] encoder_count
  input  logic                    s_axis_tuser,  // [0] func

  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [15:0] measured_ticks, [25:16] duty, [26] duty_update, [27] drive_a,
  // [28] drive_b, [29] pid_active, [31:30] zero
  output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

  epsl_cmd_t cmd;
  epsl_sts_t sts;

  // register writes go straight into the registers, so the channel never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer: accepts a request, walks the pid steps, owns the result valid
  epsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: gains, encoder delta, integral, commanded speed, duty and drive bits
  epsl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cnt_i       (s_axis_tdata[COUNTER_BITS-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: design/epsl_dp.sv
// speed loop datapath: config registers, loop state, shared gain multiplier, rpm/duty
// depends on epsl_pkg
module epsl_dp import epsl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [COUNTER_BITS-1:0] cnt_i,
  input  epsl_cmd_t               cmd_i,
  output epsl_sts_t               sts_o,
  output logic [OUT_DATA_W-1:0]   out_data_o
);

  logic [GAIN_W-1:0]       gain_p_q, gain_i_q, gain_d_q;
  logic [RPM_W-1:0]        target_q;
  logic [DIR_W-1:0]        dir_q;
  logic [COUNTER_BITS-1:0] prev_cnt_q;
  logic [DELAY_W-1:0]      delay_q;
  logic [DESIRED_W-1:0]    desired_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_err_q, err_q;
  logic signed [CS_W-1:0]    cs_q;
  logic signed [MEAS_W-1:0]  meas_q;
  logic signed [SUM_W-1:0]   prod_q, acc_q;
  logic [RPM_W-1:0]        rpm_q;
  logic                    upd_q, pid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;

  logic [COUNTER_BITS-1:0]   diff;
  logic signed [WIDE_W-1:0]  diff_w;
  logic signed [MEAS_W-1:0]  meas_n;
  logic signed [ERR_W-1:0]   err_n;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_n;
  logic signed [ERR_W:0]     derr;
  logic signed [GAIN_W:0]    mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [SUM_W-1:0]   prod_n;
  logic signed [SUM_W:0]     cs_sum;
  logic signed [CS_W-1:0]    cs_n;
  logic [RPM_W-1:0]          rpm_c;
  logic [DESIRED_W-1:0]      desired_n;
  logic [RPM_PW-1:0]         rpm_prod;
  logic [RPM_W-1:0]          rpm_n;
  logic                      cs_pos, cs_big;
  logic                      pid_go, drive_go;
  logic [DUTY_W-1:0]         duty;
  logic                      drv_a, drv_b;

  localparam logic signed [WIDE_W-1:0] MEAS_HI = WIDE_W'(32767);
  localparam logic signed [WIDE_W-1:0] MEAS_LO = -WIDE_W'(32768);
  localparam logic signed [CS_W-1:0]   CS_MAX  = {1'b0, {(CS_W-1){1'b1}}};
  localparam logic signed [CS_W-1:0]   CS_MIN  = {1'b1, {(CS_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INT_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INT_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // wrapped encoder delta, saturated to the measured field
  always_comb begin
    diff   = cnt_i - prev_cnt_q;
    diff_w = WIDE_W'($signed(diff));
    if (diff_w > MEAS_HI) begin
      meas_n = MEAS_HI[MEAS_W-1:0];
    end else if (diff_w < MEAS_LO) begin
      meas_n = MEAS_LO[MEAS_W-1:0];
    end else begin
      meas_n = diff_w[MEAS_W-1:0];
    end
  end

  assign pid_go = (desired_q != '0) && (delay_q <= DELAY_W'(1));

  // error and saturated integral
  always_comb begin
    err_n     = $signed(ERR_W'(desired_q)) - ERR_W'(meas_q);
    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_n);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_n = integ_sum[INTEG_W] ? INT_MIN : INT_MAX;
    end else begin
      integ_n = integ_sum[INTEG_W-1:0];
    end
  end

  // one shared gain multiplier
  always_comb begin
    derr = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_err_q);
    case (cmd_i.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, gain_p_q});
        mul_b = MULB_W'(err_q);
      end
      MUL_I: begin
        mul_a = $signed({1'b0, gain_i_q});
        mul_b = MULB_W'(integ_q);
      end
      MUL_D: begin
        mul_a = $signed({1'b0, gain_d_q});
        mul_b = MULB_W'(derr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_n = mul_a * mul_b;
  end

  // commanded speed update, saturated
  always_comb begin
    cs_sum = (SUM_W+1)'(cs_q) + (SUM_W+1)'(acc_q);
    if (cs_sum > (SUM_W+1)'(CS_MAX)) begin
      cs_n = CS_MAX;
    end else if (cs_sum < (SUM_W+1)'(CS_MIN)) begin
      cs_n = CS_MIN;
    end else begin
      cs_n = cs_sum[CS_W-1:0];
    end
  end

  assign drive_go = (acc_q != '0) && (delay_q == '0);

  // start target: clamp rpm register
  always_comb begin
    if (target_q == '0) begin
      rpm_c = RPM_W'(1);
    end else if (target_q > RPM_W'(MAX_RPM)) begin
      rpm_c = RPM_W'(MAX_RPM);
    end else begin
      rpm_c = target_q;
    end
    desired_n = TICKS_TAB[rpm_c];
  end

  // commanded speed to rpm by reciprocal multiply
  always_comb begin
    cs_pos   = !cs_q[CS_W-1] && (cs_q != '0);
    cs_big   = cs_q >= CS_W'(RPM_CS_MIN);
    rpm_prod = RPM_PW'(cs_q[CS_SMALL_W-1:0]) * RPM_PW'(RPM_K);
    if (!cs_pos) begin
      rpm_n = '0;
    end else if (cs_big) begin
      rpm_n = RPM_W'(MAX_RPM);
    end else begin
      rpm_n = rpm_prod[RPM_SHIFT +: RPM_W];
    end
  end

  always_comb begin
    duty  = upd_q ? DUTY_TAB[rpm_q] : '0;
    drv_a = upd_q && (dir_q == DIR_CW);
    drv_b = upd_q && (dir_q == DIR_CCW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= GAIN_P_RST;
      gain_i_q   <= GAIN_I_RST;
      gain_d_q   <= GAIN_D_RST;
      target_q   <= TARGET_RST;
      dir_q      <= DIR_STOP;
      prev_cnt_q <= '0;
      delay_q    <= DELAY_W'(START_DELAY);
      desired_q  <= '0;
      integ_q    <= '0;
      prev_err_q <= '0;
      cs_q       <= '0;
      meas_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GAIN_P:     gain_p_q <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_I:     gain_i_q <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_D:     gain_d_q <= cfg_data_i[GAIN_W-1:0];
          REG_TARGET_RPM: target_q <= cfg_data_i[RPM_W-1:0];
          REG_DIRECTION:  dir_q    <= cfg_data_i[DIR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick_load) begin
        prev_cnt_q <= cnt_i;
        meas_q     <= meas_n;
        if (!pid_go && (delay_q != '0)) begin
          delay_q <= delay_q - DELAY_W'(1);
        end
      end
      if (cmd_i.start_load) begin
        delay_q   <= DELAY_W'(START_DELAY);
        desired_q <= desired_n;
        cs_q      <= CS_W'(desired_n) << GAIN_FRAC_BITS;
      end
      if (cmd_i.err_step) begin
        integ_q <= integ_n;
      end
      if (cmd_i.mul_en && (cmd_i.mul_sel == MUL_D)) begin
        prev_err_q <= err_q;
      end
      if (cmd_i.cs_step) begin
        if (drive_go) begin
          cs_q <= cs_n;
        end else if (delay_q == DELAY_W'(1)) begin
          delay_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      upd_q <= 1'b0;
      pid_q <= pid_go;
    end
    if (cmd_i.start_load) begin
      rpm_q <= rpm_c;
      upd_q <= 1'b1;
      pid_q <= 1'b0;
    end
    if (cmd_i.err_step) begin
      err_q <= err_n;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_n;
    end
    if (cmd_i.acc_first) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.cs_step && drive_go) begin
      upd_q <= 1'b1;
    end
    if (cmd_i.rpm_step) begin
      rpm_q <= rpm_n;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {(OUT_DATA_W-OUT_FIELD_W)'(0), pid_q, drv_b, drv_a, upd_q, duty, meas_q};
    end
  end

  assign sts_o.pid_go     = pid_go;
  assign sts_o.delay_zero = (delay_q == '0);
  assign sts_o.sum_nz     = (acc_q != '0);
  assign out_data_o       = out_data_q;

endmodule

// File: design/epsl_ctrl.sv
// speed loop sequencer: accepts requests, steps the datapath, holds the result valid
// depends on epsl_pkg and the assertion macro header
`include "encoder_pid_motor_speed_loop_top_macros.svh"

module epsl_ctrl import epsl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_func_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  epsl_sts_t sts_i,
  output epsl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_P,
    S_I,
    S_D,
    S_SUM,
    S_CS,
    S_RPM,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_P;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func_i == FUNC_START) begin
            cmd_o.start_load = 1'b1;
            state_d          = S_DONE;
          end else begin
            cmd_o.tick_load = 1'b1;
            state_d         = sts_i.pid_go ? S_ERR : S_DONE;
          end
        end
      end
      S_ERR: begin
        cmd_o.err_step = 1'b1;
        state_d        = S_P;
      end
      S_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P;
        state_d       = S_I;
      end
      S_I: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_I;
        cmd_o.acc_first = 1'b1;
        state_d         = S_D;
      end
      S_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D;
        cmd_o.acc_add = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_CS;
      end
      S_CS: begin
        cmd_o.cs_step = 1'b1;
        state_d       = (sts_i.sum_nz && sts_i.delay_zero) ? S_RPM : S_DONE;
      end
      S_RPM: begin
        cmd_o.rpm_step = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `EPSL_ASSERT_IMP(a_load_has_room, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwritten")
  `EPSL_ASSERT_NEXT(a_one_request, in_acc, !in_ready_o, "second request taken while busy")
  `EPSL_ASSERT_NEXT(a_start_skips_pid, in_acc && (in_func_i == FUNC_START), state_q == S_DONE, "start ran pid steps")
  `EPSL_ASSERT_IMP(a_rpm_after_cs, state_q == S_RPM, $past(state_q) == S_CS, "rpm step out of order")

endmodule

// File: tb/sv/tb.sv
// testbench for encoder_pid_motor_speed_loop_top: directed and random requests on the stream
// ports, each result checked field by field against an in-bench speed loop predictor
// depends on epsl_pkg and encoder_pid_motor_speed_loop_top
module tb import epsl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // one result, first field in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic                     pid_active;
    logic                     drive_b;
    logic                     drive_a;
    logic                     duty_update;
    logic [DUTY_W-1:0]        duty;
    logic signed [MEAS_W-1:0] measured_ticks;
  } speed_result_t;

  localparam longint INTEG_MAX   = (longint'(1) <<< 31) - 1;
  localparam longint INTEG_MIN   = -(longint'(1) <<< 31);
  localparam longint CS_MAX      = (longint'(1) <<< 39) - 1;
  localparam longint CS_MIN      = -(longint'(1) <<< 39);
  localparam longint RPM_DIVISOR = longint'(TICKS_X10) <<< GAIN_FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam int SAT_TICKS = 48;  // enough full-scale errors to pin the commanded speed

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;   // [15:0] encoder_count
  logic                    s_axis_tuser;   // [0] func
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // [15:0] measured_ticks, [25:16] duty, [26] duty_update, [27] drive_a,
  // [28] drive_b, [29] pid_active, [31:30] zero
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  encoder_pid_motor_speed_loop_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [GAIN_W-1:0]       kp, ki, kd;
  logic [RPM_W-1:0]        rpm_set;
  logic [DIR_W-1:0]        dir_set;
  // predictor copy of the loop state
  logic [COUNTER_BITS-1:0] enc_prev;
  int                      delay_left;
  longint                  aim_ticks, integ, err_prev, speed_cmd, meas_last;

  speed_result_t           pending_drive[$];  // predicted results, oldest first
  speed_result_t           seen_res, want_res;
  int                      mismatch_count = 0;
  logic [COUNTER_BITS-1:0] enc_sent;          // last encoder count offered on a tick
  bit                      src_idle_en  = 1'b1;
  bit                      sink_idle_en = 1'b1;
  int                      sink_hold    = 0;  // cycles the result side still holds off

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rpm to duty and bridge bits
  function automatic speed_result_t with_drive(speed_result_t r, longint rpm);
    longint d;
    if (rpm > MAX_RPM) rpm = MAX_RPM;
    d = rpm * PWM_PERIOD / MAX_RPM;
    if (d > DUTY_MAX) d = DUTY_MAX;
    r.duty        = d[DUTY_W-1:0];
    r.duty_update = 1'b1;
    r.drive_a     = (dir_set == DIR_CW);
    r.drive_b     = (dir_set == DIR_CCW);
    return r;
  endfunction

  // advances the predicted loop state by one request and returns its result
  function automatic speed_result_t compute_drive_result(logic func,
                                                         logic [COUNTER_BITS-1:0] count);
    speed_result_t           r;
    logic [COUNTER_BITS-1:0] diff;
    longint                  rpm, meas, err, pid_sum;
    r = '0;
    if (func == FUNC_START) begin
      // load target, restart the delay, seed the commanded speed and drive at once
      rpm = longint'(rpm_set);
      if (rpm < 1) rpm = 1;
      if (rpm > MAX_RPM) rpm = MAX_RPM;
      delay_left = START_DELAY;
      aim_ticks  = rpm * TICKS_X10 / RPM_SCALE_X10;
      speed_cmd  = aim_ticks <<< GAIN_FRAC_BITS;
      r = with_drive(r, rpm);
      r.measured_ticks = meas_last[MEAS_W-1:0];
    end else begin
      diff      = count - enc_prev;  // wraps modulo the counter size
      meas      = longint'($signed(diff));
      enc_prev  = count;
      meas_last = meas;
      r.measured_ticks = diff;
      if (aim_ticks > 0 && delay_left <= 1) begin
        err     = aim_ticks - meas;
        integ   = clamp(integ + err, INTEG_MIN, INTEG_MAX);
        pid_sum = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * (err - err_prev);
        err_prev = err;
        r.pid_active = 1'b1;
        if (pid_sum != 0 && delay_left == 0) begin
          speed_cmd = clamp(speed_cmd + pid_sum, CS_MIN, CS_MAX);
          rpm = (speed_cmd > 0) ? speed_cmd * RPM_SCALE_X10 / RPM_DIVISOR : 0;
          r = with_drive(r, rpm);
        end else if (delay_left == 1) begin
          // last delay tick only seeds the integral and the previous error
          delay_left = 0;
        end
      end else if (delay_left > 0) begin
        delay_left = delay_left - 1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint seen, input longint want);
    if (mismatch_count < 50)
      $display("%0t ns: %0s mismatch, got %0d, want %0d", $time, what, seen, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input longint seen, input longint want);
    if (seen != want) report_mismatch(what, seen, want);
  endtask

  // register writes seen by the block update the predictor
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN_P:     kp      = cfg_data_i;
        REG_GAIN_I:     ki      = cfg_data_i;
        REG_GAIN_D:     kd      = cfg_data_i;
        REG_TARGET_RPM: rpm_set = cfg_data_i[RPM_W-1:0];
        REG_DIRECTION:  dir_set = cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // every accepted request queues its predicted result
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_drive.push_back(compute_drive_result(s_axis_tuser,
                                                   s_axis_tdata[COUNTER_BITS-1:0]));
  end

  // every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res = m_axis_tdata[OUT_FIELD_W-1:0];
      if (pending_drive.size() == 0) begin
        report_mismatch("unrequested result", seen_res.measured_ticks, 0);
      end else begin
        want_res = pending_drive.pop_front();
        check_field("measured_ticks", seen_res.measured_ticks, want_res.measured_ticks);
        check_field("duty", seen_res.duty, want_res.duty);
        check_field("duty_update", seen_res.duty_update, want_res.duty_update);
        check_field("drive_a", seen_res.drive_a, want_res.drive_a);
        check_field("drive_b", seen_res.drive_b, want_res.drive_b);
        check_field("pid_active", seen_res.pid_active, want_res.pid_active);
      end
    end
  end

  // result side: random stalls, or a counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= !(sink_idle_en && ($urandom_range(99) < 30));
    end
  end

  // called and returns at a falling edge; tvalid stays high for the next call
  task automatic send_request(input logic func, input logic [COUNTER_BITS-1:0] count);
    while (src_idle_en && ($urandom_range(99) < 30)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= count;
    if (func == FUNC_TICK) enc_sent = count;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // tick whose count moves the given number of encoder steps
  task automatic send_tick(input int delta);
    send_request(FUNC_TICK, enc_sent + COUNTER_BITS'(delta));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure_all(input logic [CFG_DATA_W-1:0] p_gain, i_gain, d_gain, rpm, dir);
    cfg_write(REG_GAIN_P, p_gain);
    cfg_write(REG_GAIN_I, i_gain);
    cfg_write(REG_GAIN_D, d_gain);
    cfg_write(REG_TARGET_RPM, rpm);
    cfg_write(REG_DIRECTION, dir);
  endtask

  // stop offering and let every outstanding result come back, then let the block settle
  task automatic drain_results();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_drive.size() != 0 && guard < 4000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (12) @(negedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(2047));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // wrapped deltas at both limits, then start requests at reset defaults
  // and with a zero target and the unused direction code
  task automatic test_wrap_and_start();
    send_request(FUNC_TICK, 16'h0000);
    send_request(FUNC_TICK, 16'hFFFF);    // one step back
    send_request(FUNC_TICK, 16'h7FFF);    // most negative delta
    send_request(FUNC_TICK, 16'hFFFE);    // most positive delta
    send_request(FUNC_START, 16'hA5A5);   // repeats last delta, target 1 rpm
    drain_results();
    configure_all(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 16'hFF00, 16'hFFFF);
    send_request(FUNC_START, 16'h5A5A);   // clamped to 1 rpm, both bridge bits low
    send_tick(0);
    drain_results();
  endtask

  // start delay count down, pid seeding tick, first driving tick
  task automatic test_start_delay();
    int k;
    configure_all(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 16'd255, 16'(DIR_CW));
    send_request(FUNC_START, 16'h0000);
    for (k = 0; k < 7; k++) send_tick(40);
    drain_results();
  endtask

  // pid runs but the sum is zero, so nothing is driven
  task automatic test_zero_gain();
    int k;
    configure_all(16'h0000, 16'h0000, 16'h0000, 16'd100, 16'(DIR_CCW));
    cfg_write(REG_SPARE, 16'hFFFF);
    send_request(FUNC_START, 16'hFFFF);
    for (k = 0; k < 6; k++) send_tick(int'(aim_ticks) + k - 2);
    drain_results();
  endtask

  // results held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int k;
    src_idle_en = 1'b0;
    configure_all(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 16'd120, 16'(DIR_CW));
    sink_hold = 150;
    send_request(FUNC_START, 16'h0000);
    for (k = 0; k < 10; k++) send_tick(int'(aim_ticks) + 3);
    drain_results();
    src_idle_en = 1'b1;
  endtask

  // start followed by a run of ticks near the target speed, with some noise
  task automatic test_random_regulation();
    int phase, k, n_seq, done;
    for (phase = 0; phase < 8; phase++) begin
      // first phase runs without any idling on either side
      src_idle_en  = (phase != 0);
      sink_idle_en = (phase != 0);
      case (phase)
        0: configure_all(16'($urandom_range(2047)), 16'($urandom_range(511)),
                         16'($urandom_range(1023)), 16'($urandom_range(4, 155)),
                         16'($urandom_range(3)));
        1: configure_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd155, 16'(DIR_CW));
        2: configure_all(16'h0000, 16'h0000, 16'h0000, 16'd4, 16'(DIR_CCW));
        default: configure_all(pick_gain(), pick_gain(), pick_gain(), 16'($urandom),
                               16'($urandom));
      endcase
      done = 0;
      while (done < 160) begin
        if ($urandom_range(99) < 10) begin
          // stray request of either kind
          send_request(1'($urandom_range(1)), 16'($urandom));
          done++;
        end else begin
          send_request(FUNC_START, 16'($urandom));
          n_seq = $urandom_range(6, 40);
          for (k = 0; k < n_seq; k++) begin
            if ($urandom_range(99) < 10) send_request(FUNC_TICK, 16'($urandom));
            else send_tick(int'(aim_ticks) + int'($urandom_range(16)) - 8);
          end
          done += n_seq + 1;
        end
      end
      drain_results();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // commanded speed driven to its top, held there, then driven to its bottom
  task automatic test_saturation();
    int k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    configure_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'd155, 16'(DIR_CW));
    send_request(FUNC_START, 16'h0000);
    for (k = 0; k < SAT_TICKS; k++) send_tick(-32768);
    drain_results();
    // small negative error: the large integral keeps the speed at the top
    configure_all(16'h0000, 16'hFFFF, 16'h0000, 16'd155, 16'(DIR_CW));
    for (k = 0; k < 20; k++) send_tick(int'(aim_ticks) + 1);
    drain_results();
    // large negative error drives the commanded speed to its bottom
    configure_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd155, 16'(DIR_CCW));
    for (k = 0; k < 150; k++) send_tick(32767);
    drain_results();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    m_axis_tready = 1'b0;
    enc_sent      = '0;
    // predictor at its reset state
    kp = GAIN_P_RST; ki = GAIN_I_RST; kd = GAIN_D_RST;
    rpm_set = TARGET_RST; dir_set = DIR_STOP;
    enc_prev = '0; delay_left = START_DELAY; aim_ticks = 0;
    integ = 0; err_prev = 0; speed_cmd = 0; meas_last = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_wrap_and_start();
    test_start_delay();
    test_zero_gain();
    test_backpressure();
    test_random_regulation();
    test_saturation();

    drain_results();
    if (pending_drive.size() != 0)
      report_mismatch("missing results", pending_drive.size(), 0);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
